// ===== design/hfbt_pkg.sv =====
// Shared types and constants for the HTTP/2 frame boundary tracker.
// No dependencies; used by every module in this folder.
package hfbt_pkg;

  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned HcntW       = 4;
  localparam int unsigned LenW        = 24;

  localparam logic [HcntW-1:0] HdrLastIdx   = HcntW'(HeaderBytes - 1);
  localparam logic [HcntW-1:0] HdrTypeIdx   = HcntW'(3);
  localparam logic [HcntW-1:0] HdrFlagsIdx  = HcntW'(4);

  localparam logic [7:0] TypeHeaders      = 8'h01;
  localparam logic [7:0] TypeContinuation = 8'h09;
  localparam int unsigned FlagEndHeadersBit = 2;

  typedef struct packed {
    logic       reusable;
    logic       header_block_open;
    logic       frame_done;
    logic [7:0] done_type;
    logic [7:0] done_flags;
  } result_t;

endpackage

// ===== design/hfbt_step.sv =====
// Frame tracker state and per-byte next-state logic.
// Depends on hfbt_pkg for constants and the result struct.
module hfbt_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             mode_i,
  input  logic [7:0]       data_byte_i,
  output hfbt_pkg::result_t result_o
);
  import hfbt_pkg::*;

  logic [HcntW-1:0] hcnt_q, hcnt_d;
  logic [LenW-1:0]  plen_q, plen_d, plen_dec;
  logic [7:0]       kind_q, kind_d;
  logic [7:0]       flags_q, flags_d;
  logic             open_q, open_d;
  logic             finish;
  logic             payload_phase;

  assign payload_phase = (hcnt_q == '0) && (plen_q != '0);
  assign plen_dec      = plen_q - LenW'(1);

  always_comb begin
    hcnt_d  = hcnt_q;
    plen_d  = plen_q;
    kind_d  = kind_q;
    flags_d = flags_q;
    open_d  = open_q;
    finish  = 1'b0;

    if (mode_i) begin
      hcnt_d  = '0;
      plen_d  = '0;
      kind_d  = '0;
      flags_d = '0;
      open_d  = 1'b0;
    end else if (payload_phase) begin
      plen_d = plen_dec;
      finish = (plen_dec == '0);
    end else begin
      if (hcnt_q < HdrTypeIdx) begin
        plen_d = {plen_q[LenW-9:0], data_byte_i};
      end else if (hcnt_q == HdrTypeIdx) begin
        kind_d = data_byte_i;
      end else if (hcnt_q == HdrFlagsIdx) begin
        flags_d = data_byte_i;
      end
      // a count at or past the last slot is treated as the last header byte
      if (hcnt_q >= HdrLastIdx) begin
        hcnt_d = '0;
        finish = (plen_d == '0);
      end else begin
        hcnt_d = hcnt_q + HcntW'(1);
      end
    end

    result_o.frame_done = finish;
    result_o.done_type  = finish ? kind_d : 8'h00;
    result_o.done_flags = finish ? flags_d : 8'h00;

    if (finish) begin
      if (kind_d == TypeHeaders) begin
        open_d = ~flags_d[FlagEndHeadersBit];
      end else if (kind_d == TypeContinuation && open_q && flags_d[FlagEndHeadersBit]) begin
        open_d = 1'b0;
      end
      plen_d  = '0;
      kind_d  = '0;
      flags_d = '0;
    end

    result_o.reusable          = (hcnt_d == '0) && (plen_d == '0) && !open_d;
    result_o.header_block_open = open_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q  <= '0;
      plen_q  <= '0;
      kind_q  <= '0;
      flags_q <= '0;
      open_q  <= 1'b0;
    end else if (step_i) begin
      hcnt_q  <= hcnt_d;
      plen_q  <= plen_d;
      kind_q  <= kind_d;
      flags_q <= flags_d;
      open_q  <= open_d;
    end
  end

endmodule

// ===== design/hfbt_out_fifo.sv =====
// Two-entry circular result queue with read and write pointers.
// Depends on hfbt_pkg for the result struct.
module hfbt_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hfbt_pkg::result_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output hfbt_pkg::result_t data_o
);
  import hfbt_pkg::*;

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/http2_frame_boundary_tracker.sv =====
// Top level of the HTTP/2 frame boundary tracker.
// Depends on hfbt_pkg, hfbt_step and hfbt_out_fifo.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one stream byte per
//   transfer, with mode_i = 1 requesting a full clear of tracker state.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   per input transfer, in order: reusable, header_block_open, frame_done,
//   done_type and done_flags.
//   Throughput: one byte per clock while the output queue has room. The
//   tracker state (header byte count, payload countdown, type, flags, block
//   flag) updates with a single 24-bit decrement/compare per byte.
//   Path: the byte lands in the input register at the transfer, and its
//   result is written to the output queue once the queue has room;
//   out_valid_o rises when the result is in the queue.
//   Stalls: a two-entry output queue absorbs results while the receiver
//   stalls; once it is full the input register holds its byte and
//   in_stall_o rises, so nothing is lost or repeated.
//   Reset: rst_ni (async, active low) clears tracker state to the
//   between-frames condition and empties all pipeline stages.
module http2_frame_boundary_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       reusable_o,
  output logic       header_block_open_o,
  output logic       frame_done_o,
  output logic [7:0] done_type_o,
  output logic [7:0] done_flags_o
);
  import hfbt_pkg::*;

  // input register stage
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic [7:0] s1_byte_q;

  logic    advance;   // s1 byte is processed and pushed this cycle
  logic    room;
  logic    pop;
  logic    q_full;
  result_t step_res;
  result_t out_res;

  assign pop        = out_valid_o && !out_stall_i;
  assign room       = !q_full || pop;
  assign advance    = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_mode_q <= mode_i;
      s1_byte_q <= data_byte_i;
    end
  end

  hfbt_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .mode_i      (s1_mode_q),
    .data_byte_i (s1_byte_q),
    .result_o    (step_res)
  );

  hfbt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (step_res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .full_o      (q_full),
    .data_o      (out_res)
  );

  assign reusable_o          = out_res.reusable;
  assign header_block_open_o = out_res.header_block_open;
  assign frame_done_o        = out_res.frame_done;
  assign done_type_o         = out_res.done_type;
  assign done_flags_o        = out_res.done_flags;

endmodule
